// ===== design/ncdd_pkg.sv =====
// ----------------------------------------------------------------------------
// ncdd_pkg
// Shared types, constants and helpers for the nixie crossfade digit driver.
// ----------------------------------------------------------------------------
package ncdd_pkg;

	// Largest value that still fits six tubes
	localparam logic [19:0] VALUE_LIMIT = 20'd999999;

	// x / 10 == (x * DIV10_MUL_20) >> DIV10_SHIFT_20 for every 20-bit x
	localparam logic [19:0] DIV10_MUL_20   = 20'd838861;
	localparam int          DIV10_SHIFT_20 = 23;

	// x / 10 == (x * DIV10_MUL_10) >> DIV10_SHIFT_10 for every 10-bit x
	localparam logic [7:0]  DIV10_MUL_10   = 8'd205;
	localparam int          DIV10_SHIFT_10 = 11;

	localparam logic [3:0]  DECIMAL_BASE   = 4'd10;
	localparam logic [3:0]  SHARE_FIRST    = 4'd8;
	localparam logic [3:0]  SHARE_FINAL    = 4'd2;

	// Reset period of 20 ms, kept as quotient and remainder by ten
	localparam logic [6:0]  PERIOD_Q_RESET = 7'd2;
	localparam logic [3:0]  PERIOD_R_RESET = 4'd0;

	// Datapath operations issued by the microcode
	typedef enum logic [2:0] {
		OP_NONE,
		OP_LOAD,
		OP_SPLIT,
		OP_TUBE_START,
		OP_EMIT_ERR,
		OP_EMIT_PULSE,
		OP_EMIT_STEADY
	} op_t;

	// Control from sequencer to datapath
	typedef struct packed {
		op_t  op;
		logic go;
	} ctl_t;

	// Status from datapath to sequencer
	typedef struct packed {
		logic in_valid;
		logic err;
		logic split_done;
		logic fade_diff;
		logic period_last;
		logic tube_last;
		logic out_free;
	} flags_t;

	function automatic logic is_emit(op_t op);
		return (op == OP_EMIT_ERR) || (op == OP_EMIT_PULSE) || (op == OP_EMIT_STEADY);
	endfunction

	// floor(p / 10) for p below 100, counted against the tens thresholds
	function automatic logic [3:0] tens_of(logic [7:0] p);
		logic [3:0] n;
		n = '0;
		for (int i = 1; i < 10; i++) begin
			if (p >= 8'(i * 10)) n = n + 4'd1;
		end
		return n;
	endfunction

endpackage

// ===== design/ncdd_seq.sv =====
// ----------------------------------------------------------------------------
// ncdd_seq
// Microcode sequencer: step counter, control store and conditional jumps.
// ----------------------------------------------------------------------------
module ncdd_seq (
	input  logic            clk,
	input  logic            arst_n,
	input  ncdd_pkg::flags_t flags,
	output ncdd_pkg::ctl_t   ctl
);
	import ncdd_pkg::*;

	typedef enum logic [2:0] {
		A_WAIT,
		A_CHECK,
		A_ERR,
		A_SPLIT,
		A_TUBE,
		A_PULSE,
		A_STEADY
	} addr_t;

	typedef enum logic [2:0] {
		C_ALWAYS,
		C_ACCEPT,
		C_ERR,
		C_SPLIT_DONE,
		C_FADE_DIFF,
		C_PERIOD_LAST,
		C_TUBE_LAST
	} cond_t;

	typedef struct packed {
		op_t   op;
		cond_t cond;
		addr_t jt;
		addr_t jf;
	} cword_t;

	// Control store
	function automatic cword_t ucode(addr_t a);
		cword_t w;
		unique case (a)
			A_WAIT:   w = '{OP_LOAD,        C_ACCEPT,      A_CHECK,  A_WAIT};
			A_CHECK:  w = '{OP_NONE,        C_ERR,         A_ERR,    A_SPLIT};
			A_ERR:    w = '{OP_EMIT_ERR,    C_ALWAYS,      A_WAIT,   A_WAIT};
			A_SPLIT:  w = '{OP_SPLIT,       C_SPLIT_DONE,  A_TUBE,   A_SPLIT};
			A_TUBE:   w = '{OP_TUBE_START,  C_FADE_DIFF,   A_PULSE,  A_STEADY};
			A_PULSE:  w = '{OP_EMIT_PULSE,  C_PERIOD_LAST, A_STEADY, A_PULSE};
			A_STEADY: w = '{OP_EMIT_STEADY, C_TUBE_LAST,   A_WAIT,   A_TUBE};
			default:  w = '{OP_NONE,        C_ALWAYS,      A_WAIT,   A_WAIT};
		endcase
		return w;
	endfunction

	addr_t  upc_q;
	cword_t cw;
	logic   cond_hit;
	logic   go;

	assign cw = ucode(upc_q);

	// Select the jump condition
	always_comb begin
		unique case (cw.cond)
			C_ALWAYS:      cond_hit = 1'b1;
			C_ACCEPT:      cond_hit = flags.in_valid;
			C_ERR:         cond_hit = flags.err;
			C_SPLIT_DONE:  cond_hit = flags.split_done;
			C_FADE_DIFF:   cond_hit = flags.fade_diff;
			C_PERIOD_LAST: cond_hit = flags.period_last;
			C_TUBE_LAST:   cond_hit = flags.tube_last;
			default:       cond_hit = 1'b1;
		endcase
	end

	// Hold an emit step until the output register has room
	assign go = !is_emit(cw.op) || flags.out_free;

	assign ctl.op = cw.op;
	assign ctl.go = go;

	// Advance the step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= A_WAIT;
		end else if (go) begin
			upc_q <= cond_hit ? cw.jt : cw.jf;
		end
	end

endmodule

// ===== design/ncdd_datapath.sv =====
// ----------------------------------------------------------------------------
// ncdd_datapath
// Period register, digit splitter, hold time arithmetic and output register.
// ----------------------------------------------------------------------------
module ncdd_datapath #(
	parameter int NUM_TUBES = 6
) (
	input  logic             clk,
	input  logic             arst_n,
	input  ncdd_pkg::ctl_t   ctl,
	output ncdd_pkg::flags_t flags,
	input  logic             cfg_valid,
	input  logic [9:0]       cfg_data,
	input  logic             in_valid,
	input  logic [19:0]      new_value,
	input  logic [19:0]      old_value,
	input  logic             crossfade,
	output logic             out_valid,
	input  logic             out_stall,
	output logic             status,
	output logic [2:0]       tube,
	output logic [3:0]       new_digit,
	output logic [3:0]       old_digit,
	output logic             steady,
	output logic [9:0]       old_hold_ms,
	output logic [9:0]       new_hold_ms,
	output logic             last
);
	import ncdd_pkg::*;

	localparam int         IW        = (NUM_TUBES > 1) ? $clog2(NUM_TUBES) : 1;
	localparam logic [2:0] LAST_TUBE = 3'(NUM_TUBES - 1);
	localparam logic [IW-1:0] LAST_DIG = IW'(NUM_TUBES - 1);

	// Period kept as quotient and remainder by ten
	logic [6:0]  per_q_q;
	logic [3:0]  per_r_q;
	logic [17:0] cfg_prod;
	logic [6:0]  cfg_quo;
	logic [9:0]  cfg_rem;

	assign cfg_prod = 18'(cfg_data) * 18'(DIV10_MUL_10);
	assign cfg_quo  = cfg_prod[DIV10_SHIFT_10 +: 7];
	assign cfg_rem  = cfg_data - 10'(cfg_quo) * 10'(DECIMAL_BASE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			per_q_q <= PERIOD_Q_RESET;
			per_r_q <= PERIOD_R_RESET;
		end else if (cfg_valid) begin
			per_q_q <= cfg_quo;
			per_r_q <= cfg_rem[3:0];
		end
	end

	// Item state
	logic          err_q;
	logic          fade_q;
	logic [19:0]   nv_q;
	logic [19:0]   ov_q;
	logic [IW-1:0] dig_q;
	logic [2:0]    tube_q;
	logic [3:0]    share_q;
	logic [3:0]    nd_q [NUM_TUBES];
	logic [3:0]    od_q [NUM_TUBES];

	// One decimal digit per step from each value
	logic [39:0] nprod, oprod;
	logic [16:0] nquo, oquo;
	logic [19:0] nrem, orem;

	assign nprod = 40'(nv_q) * 40'(DIV10_MUL_20);
	assign oprod = 40'(ov_q) * 40'(DIV10_MUL_20);
	assign nquo  = nprod[DIV10_SHIFT_20 +: 17];
	assign oquo  = oprod[DIV10_SHIFT_20 +: 17];
	assign nrem  = nv_q - 20'(nquo) * 20'(DECIMAL_BASE);
	assign orem  = ov_q - 20'(oquo) * 20'(DECIMAL_BASE);

	logic          do_step;
	logic [IW-1:0] tidx;
	logic [3:0]    cur_nd, cur_od;

	assign do_step = ctl.go;
	assign tidx    = tube_q[IW-1:0];
	assign cur_nd  = nd_q[tidx];
	assign cur_od  = od_q[tidx];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			err_q   <= 1'b0;
			fade_q  <= 1'b0;
			dig_q   <= '0;
			tube_q  <= '0;
			share_q <= SHARE_FIRST;
		end else if (do_step) begin
			unique case (ctl.op)
				OP_LOAD: begin
					if (in_valid) begin
						err_q  <= (new_value > VALUE_LIMIT) || (old_value > VALUE_LIMIT);
						fade_q <= crossfade;
						dig_q  <= LAST_DIG;
						tube_q <= '0;
					end
				end
				OP_SPLIT: begin
					dig_q <= dig_q - IW'(1);
				end
				OP_TUBE_START: begin
					share_q <= SHARE_FIRST;
				end
				OP_EMIT_PULSE: begin
					share_q <= share_q - 4'd1;
				end
				OP_EMIT_STEADY: begin
					tube_q <= tube_q + 3'd1;
				end
				default: begin
				end
			endcase
		end
	end

	// Working values and digit store
	always_ff @(posedge clk) begin
		if (ctl.op == OP_LOAD && in_valid) begin
			nv_q <= new_value;
			ov_q <= old_value;
		end else if (ctl.op == OP_SPLIT) begin
			nv_q <= 20'(nquo);
			ov_q <= 20'(oquo);
			nd_q[dig_q] <= nrem[3:0];
			od_q[dig_q] <= orem[3:0];
		end
	end

	// Hold times: floor(P*s/10) = q*s + floor(r*s/10)
	logic [3:0]  new_share;
	logic [10:0] old_full, new_full;

	assign new_share = DECIMAL_BASE - share_q;
	assign old_full  = 11'(per_q_q) * 11'(share_q)
	                   + 11'(tens_of(8'(per_r_q) * 8'(share_q)));
	assign new_full  = 11'(per_q_q) * 11'(new_share)
	                   + 11'(tens_of(8'(per_r_q) * 8'(new_share)));

	// Output register
	logic out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (do_step && is_emit(ctl.op)) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (do_step && is_emit(ctl.op)) begin
			status      <= (ctl.op == OP_EMIT_ERR);
			tube        <= (ctl.op == OP_EMIT_ERR) ? 3'd0 : tube_q;
			new_digit   <= (ctl.op == OP_EMIT_ERR) ? 4'd0 : cur_nd;
			old_digit   <= (ctl.op == OP_EMIT_ERR) ? 4'd0 : cur_od;
			steady      <= (ctl.op == OP_EMIT_STEADY);
			old_hold_ms <= (ctl.op == OP_EMIT_PULSE) ? old_full[9:0] : 10'd0;
			new_hold_ms <= (ctl.op == OP_EMIT_PULSE && share_q != SHARE_FINAL)
			               ? new_full[9:0] : 10'd0;
			last        <= (ctl.op == OP_EMIT_ERR)
			               || (ctl.op == OP_EMIT_STEADY && tube_q == LAST_TUBE);
		end
	end

	assign out_valid = out_valid_q;

	// Status toward the sequencer
	assign flags.in_valid    = in_valid;
	assign flags.err         = err_q;
	assign flags.split_done  = (dig_q == '0);
	assign flags.fade_diff   = fade_q && (cur_nd != cur_od);
	assign flags.period_last = (share_q == SHARE_FINAL);
	assign flags.tube_last   = (tube_q == LAST_TUBE);
	assign flags.out_free    = !out_valid_q || !out_stall;

endmodule

// ===== design/nixie_crossfade_digit_driver.sv =====
// ----------------------------------------------------------------------------
// nixie_crossfade_digit_driver
// Splits a new and an old value into tube digits and emits cathode steps.
// ----------------------------------------------------------------------------
// One input word is taken at a time. Its results leave at most one per cycle
// from a small microcoded program: a step to take the word, a range test step,
// split steps for both values (one decimal digit per cycle through a
// reciprocal multiply), then per tube a setup step, seven pulse words when
// the digits differ and crossfade is set, and one steady word. A stalled
// output word holds the program at its emit step. The period register may be
// written at any time the block is idle and takes effect on the next word.
// ----------------------------------------------------------------------------
module nixie_crossfade_digit_driver #(
	parameter int NUM_TUBES = 6
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [9:0]  cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [19:0] new_value,
	input  logic [19:0] old_value,
	input  logic        crossfade,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        status,
	output logic [2:0]  tube,
	output logic [3:0]  new_digit,
	output logic [3:0]  old_digit,
	output logic        steady,
	output logic [9:0]  old_hold_ms,
	output logic [9:0]  new_hold_ms,
	output logic        last
);
	import ncdd_pkg::*;

	ctl_t   ctl;
	flags_t flags;

	// Accept a word only at the load step
	assign in_stall  = (ctl.op != OP_LOAD);
	assign cfg_ready = 1'b1;

	ncdd_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.flags  (flags),
		.ctl    (ctl)
	);

	ncdd_datapath #(
		.NUM_TUBES (NUM_TUBES)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (ctl),
		.flags       (flags),
		.cfg_valid   (cfg_valid),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.new_value   (new_value),
		.old_value   (old_value),
		.crossfade   (crossfade),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.status      (status),
		.tube        (tube),
		.new_digit   (new_digit),
		.old_digit   (old_digit),
		.steady      (steady),
		.old_hold_ms (old_hold_ms),
		.new_hold_ms (new_hold_ms),
		.last        (last)
	);

	// After a word is taken the block is busy with it
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken again right after an accept");

	// An error word is always the only and final one
	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status |-> last && !steady)
		else $error("error word not marked last");

	// A pulse word never ends an item
	a_pulse_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !status && !steady |-> !last)
		else $error("pulse word marked last");

	// The steady word of the rightmost tube ends the item
	a_steady_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && steady |-> (last == (tube == 3'(NUM_TUBES - 1))))
		else $error("steady word last flag wrong");

endmodule

// ===== tb/tb_nixie_crossfade_digit_driver.sv =====
// ----------------------------------------------------------------------------
// tb_nixie_crossfade_digit_driver
// Self-checking bench for the nixie crossfade digit driver. A directed table of
// number pairs is followed by random pairs under several pulse periods. Each
// accepted word, bar typed errors, runs through a local model of the digit split
// and fade timing. Every cathode word that leaves the block is compared, field
// by field, with the oldest predicted word. Both sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_nixie_crossfade_digit_driver;

	localparam int          NUM_TUBES        = 6;
	localparam int          FADE_PERIODS     = 7;
	localparam int unsigned VALUE_MAX        = 999_999;
	localparam logic [9:0]  PERIOD_AT_RESET  = 10'd20;
	localparam int          PHASES           = 6;
	localparam int          RANDOM_PER_PHASE = 69;
	localparam int          LONG_HOLD_CYCLES = 400;
	localparam int          DRAIN_CYCLES     = 80;
	localparam int          LIMIT_CYCLES     = 1_500_000;

	localparam int unsigned POW10 [NUM_TUBES] = '{1, 10, 100, 1000, 10000, 100000};

	// One cathode word as it leaves the block
	typedef struct packed {
		logic       status;
		logic [2:0] tube;
		logic [3:0] new_digit;
		logic [3:0] old_digit;
		logic       steady;
		logic [9:0] old_hold;
		logic [9:0] new_hold;
		logic       last;
	} cathode_step_t;

	localparam cathode_step_t RANGE_ERROR_STEP =
		'{1'b1, 3'd0, 4'd0, 4'd0, 1'b0, 10'd0, 10'd0, 1'b1};

	// One row of the directed table; range_err rows carry a typed-in result
	typedef struct packed {
		logic [19:0] nv;
		logic [19:0] ov;
		logic        xf;
		logic        range_err;
	} number_pair_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [9:0]  cfg_data;
	logic        in_valid;
	logic        in_stall;
	logic [19:0] new_value;
	logic [19:0] old_value;
	logic        crossfade;
	logic        out_valid;
	logic        out_stall;
	logic        status;
	logic [2:0]  tube;
	logic [3:0]  new_digit;
	logic [3:0]  old_digit;
	logic        steady;
	logic [9:0]  old_hold_ms;
	logic [9:0]  new_hold_ms;
	logic        last;

	cathode_step_t pending_steps [$];
	logic [9:0]    period_ms;
	bit            no_idle;
	bit            hold_output;
	int            fail_count;
	int            numbers_sent;
	int            range_errors;
	int            words_checked;
	int            pulse_words;
	int            cycle_count;

	number_pair_t directed_pairs [17] = '{
		'{20'd0,       20'd0,       1'b0, 1'b0},
		'{20'd0,       20'd0,       1'b1, 1'b0},
		'{20'd999999,  20'd0,       1'b1, 1'b0},
		'{20'd0,       20'd999999,  1'b0, 1'b0},
		'{20'd999999,  20'd999999,  1'b1, 1'b0},
		'{20'd1000000, 20'd0,       1'b1, 1'b1},
		'{20'd0,       20'd1000000, 1'b1, 1'b1},
		'{20'd1048575, 20'd1048575, 1'b0, 1'b1},
		'{20'd999999,  20'd1048575, 1'b1, 1'b1},
		'{20'd1048575, 20'd0,       1'b0, 1'b1},
		'{20'd1000000, 20'd1000000, 1'b1, 1'b1},
		'{20'd123456,  20'd654321,  1'b1, 1'b0},
		'{20'd100000,  20'd0,       1'b1, 1'b0},
		'{20'd5,       20'd4,       1'b1, 1'b0},
		'{20'd987654,  20'd123450,  1'b1, 1'b0},
		'{20'd999999,  20'd999998,  1'b1, 1'b0},
		'{20'd555555,  20'd444444,  1'b0, 1'b0}
	};

	nixie_crossfade_digit_driver #(
		.NUM_TUBES (NUM_TUBES)
	) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.new_value   (new_value),
		.old_value   (old_value),
		.crossfade   (crossfade),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.status      (status),
		.tube        (tube),
		.new_digit   (new_digit),
		.old_digit   (old_digit),
		.steady      (steady),
		.old_hold_ms (old_hold_ms),
		.new_hold_ms (new_hold_ms),
		.last        (last)
	);

	// Free-running clock
	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Work out the cathode words that one number pair produces
	task automatic predict_steps(input logic [19:0] nv, input logic [19:0] ov, input logic xf);
		logic [3:0]    nd [NUM_TUBES];
		logic [3:0]    od [NUM_TUBES];
		int unsigned   nrest;
		int unsigned   orest;
		int unsigned   p;
		int unsigned   share;
		int unsigned   oh;
		int unsigned   nh;
		cathode_step_t s;
		if (nv > VALUE_MAX || ov > VALUE_MAX) begin
			pending_steps.push_back(RANGE_ERROR_STEP);
			range_errors++;
			return;
		end
		nrest = 32'(nv);
		orest = 32'(ov);
		// Rightmost tube takes the least significant digit
		for (int t = NUM_TUBES - 1; t >= 0; t--) begin
			nd[t] = 4'(nrest % 10);
			od[t] = 4'(orest % 10);
			nrest = nrest / 10;
			orest = orest / 10;
		end
		p = 32'(period_ms);
		for (int t = 0; t < NUM_TUBES; t++) begin
			s = '0;
			s.tube = 3'(t);
			s.new_digit = nd[t];
			s.old_digit = od[t];
			if (xf && nd[t] != od[t]) begin
				for (int k = 0; k < FADE_PERIODS; k++) begin
					share = 8 - k;
					oh = p * share / 10;
					nh = (k == FADE_PERIODS - 1) ? 0 : p * (10 - share) / 10;
					s.old_hold = 10'(oh);
					s.new_hold = 10'(nh);
					pending_steps.push_back(s);
				end
			end
			s.steady = 1'b1;
			s.old_hold = '0;
			s.new_hold = '0;
			s.last = (t == NUM_TUBES - 1);
			pending_steps.push_back(s);
		end
	endtask

	// Offer one number pair after a random gap and hold it until taken
	task automatic send_pair(input logic [19:0] nv, input logic [19:0] ov, input logic xf,
			input logic typed_err);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 13);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid  <= 1'b1;
		new_value <= nv;
		old_value <= ov;
		crossfade <= xf;
		do @(posedge clk); while (in_stall);
		if (typed_err) begin
			pending_steps.push_back(RANGE_ERROR_STEP);
			range_errors++;
		end else begin
			predict_steps(nv, ov, xf);
		end
		numbers_sent++;
	endtask

	// Hold until every predicted word has left the block
	task automatic wait_drain();
		do @(posedge clk); while (pending_steps.size() != 0);
	endtask

	task automatic write_period(input logic [9:0] p);
		cfg_valid <= 1'b1;
		cfg_data  <= p;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		period_ms = p;
	endtask

	// Random value: mostly in range, some at the limit, some any 20-bit pattern
	function automatic logic [19:0] pick_value();
		case ($urandom_range(0, 7))
			0: return 20'($urandom_range(0, 20'hFFFFF));
			1: return 20'($urandom_range(999_980, 1_000_020));
			2: return 20'($urandom_range(0, 99));
			default: return 20'($urandom_range(0, VALUE_MAX));
		endcase
	endfunction

	// Replace one to three decimal digits with random ones
	function automatic logic [19:0] alter_digits(input logic [19:0] v);
		int unsigned x;
		int unsigned i;
		x = 32'(v);
		repeat ($urandom_range(1, 3)) begin
			i = $urandom_range(0, NUM_TUBES - 1);
			x = x - ((x / POW10[i]) % 10) * POW10[i] + $urandom_range(0, 9) * POW10[i];
		end
		return 20'(x);
	endfunction

	// Stimulus and configuration
	initial begin : stimulus
		logic [19:0] nv;
		logic [19:0] ov;
		logic        xf;
		arst_n      <= 1'b0;
		cfg_valid   <= 1'b0;
		cfg_data    <= '0;
		in_valid    <= 1'b0;
		new_value   <= '0;
		old_value   <= '0;
		crossfade   <= 1'b0;
		period_ms   = PERIOD_AT_RESET;
		no_idle     = 1'b0;
		hold_output = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed pairs at the reset period
		foreach (directed_pairs[i]) begin
			send_pair(directed_pairs[i].nv, directed_pairs[i].ov, directed_pairs[i].xf,
				directed_pairs[i].range_err);
		end
		in_valid <= 1'b0;
		wait_drain();

		// Random pairs under each period setting
		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: write_period(10'd1);
				1: write_period(10'd1000);
				2: write_period(10'd0);
				3: write_period(10'd1023);
				4: write_period(10'($urandom_range(2, 999)));
				default: write_period(PERIOD_AT_RESET);
			endcase
			// Let the receiver back up the block early in this phase
			if (ph == 2) hold_output = 1'b1;
			for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
				if (i % 16 == 0) no_idle = ($urandom_range(0, 3) == 0);
				// Pause the sender until the block has emptied out
				if (ph == 3 && i == 35) begin
					in_valid <= 1'b0;
					wait_drain();
				end
				nv = pick_value();
				case ($urandom_range(0, 7))
					0, 1, 2, 3: ov = alter_digits(nv);
					4:          ov = nv;
					default:    ov = pick_value();
				endcase
				xf = ($urandom_range(0, 3) != 0);
				send_pair(nv, ov, xf, 1'b0);
			end
			in_valid <= 1'b0;
			wait_drain();
		end

		// Catch any stray words after the last expected one
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Sent %0d number pairs (%0d out of range) under 7 pulse periods,",
			numbers_sent, range_errors);
		$display("checked %0d cathode words, %0d of them crossfade pulses.",
			words_checked, pulse_words);
		if (fail_count == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

	// Output side: random stall per word, one long hold on request
	initial begin : receiver
		int n;
		out_stall <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			n = no_idle ? 0 : $urandom_range(0, 13);
			if (hold_output) begin
				n = LONG_HOLD_CYCLES;
				hold_output = 1'b0;
			end
			if (n > 0) begin
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
		end
	end

	function automatic void note_field(input string nm, input logic [9:0] want_v,
			input logic [9:0] got_v);
		if (got_v !== want_v)
			$display("%0t: %s expected %0d, actual %0d", $time, nm, want_v, got_v);
	endfunction

	// Compare each accepted word with the oldest prediction
	always @(posedge clk) begin : step_checker
		cathode_step_t want;
		cathode_step_t got;
		if (arst_n && out_valid && !out_stall) begin
			got = '{status, tube, new_digit, old_digit, steady, old_hold_ms, new_hold_ms, last};
			if (pending_steps.size() == 0) begin
				$display("%0t: unexpected word, expected none, actual %h", $time, got);
				fail_count++;
			end else begin
				want = pending_steps.pop_front();
				words_checked++;
				if (!want.status && !want.steady) pulse_words++;
				if (got !== want) begin
					note_field("status", 10'(want.status), 10'(got.status));
					note_field("tube", 10'(want.tube), 10'(got.tube));
					note_field("new_digit", 10'(want.new_digit), 10'(got.new_digit));
					note_field("old_digit", 10'(want.old_digit), 10'(got.old_digit));
					note_field("steady", 10'(want.steady), 10'(got.steady));
					note_field("old_hold_ms", want.old_hold, got.old_hold);
					note_field("new_hold_ms", want.new_hold, got.new_hold);
					note_field("last", 10'(want.last), 10'(got.last));
					fail_count++;
				end
			end
		end
	end

	// Stop a hung run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("%0t: timeout with %0d words still expected", $time, pending_steps.size());
			$display("CHECK FAILED");
			$finish;
		end
	end

endmodule
